// ===== design/tlre_pkg.sv =====
// ----------------------------------------------------------------------------
// tlre_pkg
// Shared types and constants of the track label run-length encoder.
// ----------------------------------------------------------------------------
package tlre_pkg;

   // Default sizes; the top level exposes them as parameters.
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_MAX_COLUMNS = 4096;

   // Fixed field widths.
   localparam int LABEL_W = 32;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 23;
   localparam int ROWS_W  = 11;
   localparam int COLS_W  = 13;

   // Register file.
   localparam int  CSR_ADDR_W   = 3;
   localparam int  CSR_DATA_W   = 32;
   localparam logic CSR_ROWS    = 1'b0;
   localparam logic CSR_COLS    = 1'b1;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd1024;
   localparam logic [COLS_W-1:0] COLS_RESET = 13'd4096;

   // Word kinds.
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LABEL = 2'd2;

   // Most words a single item can produce.
   localparam int MAX_WORDS = 4;
   localparam int SLOT_W    = $clog2(MAX_WORDS);
   localparam int NUM_W     = $clog2(MAX_WORDS + 1);

   typedef struct packed {
      logic [LABEL_W-1:0] code;
      logic [KIND_W-1:0]  kind;
   } word_type;

   // One classified item, handed from the front end to the back end.
   typedef struct packed {
      word_type [MAX_WORDS-1:0] words;
      logic [NUM_W-1:0]         count;
      logic                     col_end;
      logic                     buf_end;
   } cmd_type;

endpackage

// ===== design/tlre_if.sv =====
// ----------------------------------------------------------------------------
// tlre_if
// Valid/ready channels for label items and encoded word items.
// ----------------------------------------------------------------------------
interface tlre_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] track_label;

   modport source (output valid, output track_label, input ready);
   modport sink   (input valid, input track_label, output ready);
endinterface

interface tlre_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] code_word;
   logic [1:0]         word_kind;
   logic [22:0]        word_position;
   logic               column_first;
   logic               last_of_item;

   modport source (output valid, output code_word, output word_kind,
                   output word_position, output column_first, output last_of_item,
                   input ready);
   modport sink   (input valid, input code_word, input word_kind,
                   input word_position, input column_first, input last_of_item,
                   output ready);
endinterface

// ===== design/tlre_csr.sv =====
// ----------------------------------------------------------------------------
// tlre_csr
// APB-style register file: rows per column and columns per buffer.
// ----------------------------------------------------------------------------
module tlre_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tlre_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tlre_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tlre_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output logic [tlre_pkg::ROWS_W-1:0]      rows_per_column,
   output logic [tlre_pkg::COLS_W-1:0]      columns_per_buffer
);
   import tlre_pkg::*;

   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_en) begin
         unique case (paddr[2])
            CSR_ROWS: rows_in = pwdata[ROWS_W-1:0];
            CSR_COLS: cols_in = pwdata[COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_ROWS: prdata = CSR_DATA_W'(rows_ff);
         CSR_COLS: prdata = CSR_DATA_W'(cols_ff);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign rows_per_column    = rows_ff;
   assign columns_per_buffer = cols_ff;
endmodule

// ===== design/tlre_front.sv =====
// ----------------------------------------------------------------------------
// tlre_front
// Accepts label items, tracks the open runs and row/column counters, and
// turns each item into a command of zero to four words.
// ----------------------------------------------------------------------------
module tlre_front #(
   parameter int MAX_ROWS    = tlre_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = tlre_pkg::DEF_MAX_COLUMNS
) (
   input  logic                         clock,
   input  logic                         reset,
   tlre_req_if.sink                     req_if,
   input  logic [tlre_pkg::ROWS_W-1:0]  rows_per_column,
   input  logic [tlre_pkg::COLS_W-1:0]  columns_per_buffer,
   input  logic                         queue_full,
   output logic                         push,
   output tlre_pkg::cmd_type            push_cmd
);
   import tlre_pkg::*;

   localparam int RUN_W = $clog2(MAX_ROWS + 1);
   localparam int COL_W = $clog2(MAX_COLUMNS + 1);

   logic [RUN_W-1:0]   empty_run_ff, empty_run_in;
   logic [RUN_W-1:0]   label_run_ff, label_run_in;
   logic [LABEL_W-1:0] cur_label_ff, cur_label_in;
   logic [RUN_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;

   logic [RUN_W-1:0]   eff_rows;
   logic [COL_W-1:0]   eff_cols;
   logic [RUN_W-1:0]   row_next;
   logic [COL_W-1:0]   col_next;
   logic [LABEL_W-1:0] lab;
   logic               is_empty;
   logic [NUM_W-1:0]   n;
   cmd_type            cmd;

   // Clamp the limits into their legal ranges.
   always_comb begin
      if (rows_per_column == '0) begin
         eff_rows = RUN_W'(1);
      end else if (32'(rows_per_column) > 32'(MAX_ROWS)) begin
         eff_rows = RUN_W'(MAX_ROWS);
      end else begin
         eff_rows = RUN_W'(rows_per_column);
      end
      if (columns_per_buffer == '0) begin
         eff_cols = COL_W'(1);
      end else if (32'(columns_per_buffer) > 32'(MAX_COLUMNS)) begin
         eff_cols = COL_W'(MAX_COLUMNS);
      end else begin
         eff_cols = COL_W'(columns_per_buffer);
      end
   end

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;
   assign lab          = req_if.track_label;
   assign is_empty     = (lab == '0) || lab[LABEL_W-1];
   assign row_next     = row_ff + RUN_W'(1);
   assign col_next     = col_ff + COL_W'(1);

   always_comb begin
      cmd          = '0;
      n            = '0;
      empty_run_in = empty_run_ff;
      label_run_in = label_run_ff;
      cur_label_in = cur_label_ff;
      row_in       = row_next;
      col_in       = col_ff;

      // Run bookkeeping for this sample.
      if (is_empty) begin
         if (label_run_ff != '0) begin
            cmd.words[n[SLOT_W-1:0]] = '{code: LABEL_W'(label_run_ff), kind: KIND_COUNT};
            n = n + NUM_W'(1);
            cmd.words[n[SLOT_W-1:0]] = '{code: cur_label_ff, kind: KIND_LABEL};
            n = n + NUM_W'(1);
            label_run_in = '0;
            cur_label_in = '0;
         end
         empty_run_in = empty_run_ff + RUN_W'(1);
      end else if (lab != cur_label_ff) begin
         if (empty_run_ff != '0) begin
            cmd.words[n[SLOT_W-1:0]] =
               '{code: LABEL_W'(0) - LABEL_W'(empty_run_ff), kind: KIND_EMPTY};
            n = n + NUM_W'(1);
            empty_run_in = '0;
         end else begin
            // also covers the zero-length pair at column start
            cmd.words[n[SLOT_W-1:0]] = '{code: LABEL_W'(label_run_ff), kind: KIND_COUNT};
            n = n + NUM_W'(1);
            cmd.words[n[SLOT_W-1:0]] = '{code: cur_label_ff, kind: KIND_LABEL};
            n = n + NUM_W'(1);
         end
         cur_label_in = lab;
         label_run_in = RUN_W'(1);
      end else begin
         label_run_in = label_run_ff + RUN_W'(1);
      end

      // Column end: flush open runs.
      if (row_next >= eff_rows) begin
         cmd.col_end = 1'b1;
         if (empty_run_in != '0) begin
            cmd.words[n[SLOT_W-1:0]] =
               '{code: LABEL_W'(0) - LABEL_W'(empty_run_in), kind: KIND_EMPTY};
            n = n + NUM_W'(1);
         end
         if (label_run_in != '0) begin
            cmd.words[n[SLOT_W-1:0]] = '{code: LABEL_W'(label_run_in), kind: KIND_COUNT};
            n = n + NUM_W'(1);
            cmd.words[n[SLOT_W-1:0]] = '{code: cur_label_in, kind: KIND_LABEL};
            n = n + NUM_W'(1);
         end
         empty_run_in = '0;
         label_run_in = '0;
         cur_label_in = '0;
         row_in       = '0;
         if (col_next >= eff_cols) begin
            cmd.buf_end = 1'b1;
            col_in      = '0;
         end else begin
            col_in = col_next;
         end
      end
      cmd.count = n;
   end

   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_run_ff <= '0;
         label_run_ff <= '0;
         cur_label_ff <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else if (push) begin
         empty_run_ff <= empty_run_in;
         label_run_ff <= label_run_in;
         cur_label_ff <= cur_label_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end
endmodule

// ===== design/tlre_queue.sv =====
// ----------------------------------------------------------------------------
// tlre_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module tlre_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tlre_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output tlre_pkg::cmd_type  head
);
   import tlre_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head       = slot_ff[rd_ff];

   always_comb begin
      wr_in   = push ? ~wr_ff : wr_ff;
      rd_in   = pop ? ~rd_ff : rd_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end
endmodule

// ===== design/tlre_back.sv =====
// ----------------------------------------------------------------------------
// tlre_back
// Walks the words of each queued command, numbers them in the buffer and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module tlre_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  tlre_pkg::cmd_type  head,
   output logic               pop,
   tlre_rsp_if.source         rsp_if
);
   import tlre_pkg::*;

   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]   wc_ff, wc_in;
   logic               opened_ff, opened_in;

   logic               valid_ff, valid_in;
   logic [LABEL_W-1:0] code_ff, code_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               first_ff, first_in;
   logic               last_ff, last_in;

   logic               advance;
   logic               at_last;
   word_type           word;

   assign advance = head_valid && (!valid_ff || rsp_if.ready);
   assign word    = head.words[idx_ff];
   assign at_last = ((NUM_W'(idx_ff) + NUM_W'(1)) == head.count);

   always_comb begin
      pop       = 1'b0;
      idx_in    = idx_ff;
      wc_in     = wc_ff;
      opened_in = opened_ff;
      valid_in  = valid_ff && !rsp_if.ready;
      code_in   = code_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      first_in  = first_ff;
      last_in   = last_ff;

      if (advance) begin
         if (head.count == '0) begin
            pop = 1'b1;
         end else begin
            valid_in  = 1'b1;
            code_in   = word.code;
            kind_in   = word.kind;
            pos_in    = wc_ff;
            first_in  = !opened_ff;
            last_in   = at_last;
            wc_in     = wc_ff + POS_W'(1);
            opened_in = 1'b1;
            if (at_last) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         // column and buffer ends take effect after the item's last word
         if (pop && head.col_end) begin
            opened_in = 1'b0;
         end
         if (pop && head.buf_end) begin
            wc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         wc_ff     <= '0;
         opened_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         wc_ff     <= wc_in;
         opened_ff <= opened_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      first_ff <= first_in;
      last_ff  <= last_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.code_word     = code_ff;
   assign rsp_if.word_kind     = kind_ff;
   assign rsp_if.word_position = pos_ff;
   assign rsp_if.column_first  = first_ff;
   assign rsp_if.last_of_item  = last_ff;
endmodule

// ===== design/track_label_run_length_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// track_label_run_length_encoder_unit
// Order: an accepted item is written into the command queue; its first word
//   moves on to the output register; its other words follow one per cycle
//   while the receiver is ready.
// Throughput: one item accepted per cycle while the two-entry command queue
//   has room. An item makes at most four words; one that makes no word is
//   still popped by the back end.
// Reset: synchronous, active high; runs, counters and queue cleared, the
//   registers return to 1024 rows and 4096 columns.
// ----------------------------------------------------------------------------
// Structure:
//   tlre_csr   - register file (APB-style, addresses 0 and 4)
//   tlre_front - classifies each item against the open run state, handles
//                column and buffer ends, builds a word list per item
//   tlre_queue - two-entry command queue so either side can stall alone
//   tlre_back  - emits words one per cycle unless stalled; assigns position,
//                the column-first flag, and restarts position at buffer end
// ----------------------------------------------------------------------------
module track_label_run_length_encoder_unit #(
   parameter int MAX_ROWS    = tlre_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = tlre_pkg::DEF_MAX_COLUMNS
) (
   input  logic                             clock,
   input  logic                             reset,
   tlre_req_if.sink                         req_if,
   tlre_rsp_if.source                       rsp_if,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tlre_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tlre_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tlre_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import tlre_pkg::*;

   logic [ROWS_W-1:0] rows_per_column;
   logic [COLS_W-1:0] columns_per_buffer;

   // front -> queue
   logic    push;
   logic    queue_full;
   cmd_type push_cmd;

   // queue -> back
   logic    pop;
   logic    head_valid;
   cmd_type head;

   tlre_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .rows_per_column    (rows_per_column),
      .columns_per_buffer (columns_per_buffer)
   );

   // Front end: one item per cycle whenever the queue is not full.
   tlre_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_if             (req_if),
      .rows_per_column    (rows_per_column),
      .columns_per_buffer (columns_per_buffer),
      .queue_full         (queue_full),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   tlre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Back end: word serialiser behind a registered output.
   tlre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives signed track labels into the run-length encoder and checks every
// word that comes out (code, kind, position, column-first flag and the
// last-of-item flag) against a predictor of the encoder that runs beside it.
// Covers the register limits, column and buffer ends, back-pressure and random
// runs with idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tlre_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with nothing accepted
   localparam int SETTLE_CYCLES  = 8;      // after the last word, before a write
   localparam int RANDOM_ITEMS   = 180;

   // One encoded word as it should appear on the result channel.
   typedef struct {
      logic [LABEL_W-1:0] code;
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   pos;
      logic               first;
      logic               last;
   } coded_word_type;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tlre_req_if req_ch ();
   tlre_rsp_if rsp_ch ();

   track_label_run_length_encoder_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Encoder predictor: its own copy of the registers and the run state.
   // ---------------------------------------------------------------------------
   logic [ROWS_W-1:0]  rows_reg;
   logic [COLS_W-1:0]  cols_reg;
   logic [ROWS_W-1:0]  empty_len;      // open run of empty samples
   logic [ROWS_W-1:0]  label_len;      // open run of one label
   logic [LABEL_W-1:0] open_label;     // label of the open run, 0 if none
   logic [ROWS_W-1:0]  row_cnt;
   logic [COLS_W-1:0]  col_cnt;
   logic [POS_W-1:0]   word_cnt;
   logic               col_open;       // a word of this column is already out

   coded_word_type item_words[MAX_WORDS];
   int             item_word_cnt;
   coded_word_type pending_words[$];   // words still to come, oldest first

   int  mismatches = 0;
   int  labels_sent = 0;
   bit  idling_on = 1'b0;              // random gaps and stalls on both sides
   int  long_hold = 0;                 // receiver hold-off request, in cycles

   function automatic void reset_encoder_state();
      rows_reg   = ROWS_RESET;
      cols_reg   = COLS_RESET;
      empty_len  = '0;
      label_len  = '0;
      open_label = '0;
      row_cnt    = '0;
      col_cnt    = '0;
      word_cnt   = '0;
      col_open   = 1'b0;
   endfunction

   function automatic void emit_word(input logic [LABEL_W-1:0] code,
                                     input logic [KIND_W-1:0] kind);
      item_words[item_word_cnt] = '{code: code, kind: kind, pos: word_cnt,
                                    first: !col_open, last: 1'b0};
      item_word_cnt++;
      col_open = 1'b1;
      word_cnt = word_cnt + 1'b1;
   endfunction

   function automatic void emit_run_pair();
      emit_word(LABEL_W'(label_len), KIND_COUNT);
      emit_word(open_label, KIND_LABEL);
   endfunction

   function automatic logic [ROWS_W-1:0] rows_limit();
      if (rows_reg == 0) return ROWS_W'(1);
      if (rows_reg > DEF_MAX_ROWS) return ROWS_W'(DEF_MAX_ROWS);
      return rows_reg;
   endfunction

   function automatic logic [COLS_W-1:0] cols_limit();
      if (cols_reg == 0) return COLS_W'(1);
      if (cols_reg > DEF_MAX_COLUMNS) return COLS_W'(DEF_MAX_COLUMNS);
      return cols_reg;
   endfunction

   // Works out the words caused by one accepted label and queues them.
   function automatic void encode_label(input logic signed [LABEL_W-1:0] lab);
      item_word_cnt = 0;
      if (lab <= 0) begin
         if (label_len > 0) begin
            emit_run_pair();
            label_len  = '0;
            open_label = '0;
         end
         empty_len = empty_len + 1'b1;
      end else if (lab != open_label) begin
         // Closes the empty run, or else the open label run; at a column
         // start with nothing open this gives the zero-length pair.
         if (empty_len > 0) begin
            emit_word(32'd0 - LABEL_W'(empty_len), KIND_EMPTY);
            empty_len = '0;
         end else begin
            emit_run_pair();
         end
         open_label = lab;
         label_len  = ROWS_W'(1);
      end else begin
         label_len = label_len + 1'b1;
      end

      // Column end: reaching or passing the limit flushes whatever is open.
      row_cnt = row_cnt + 1'b1;
      if (row_cnt >= rows_limit()) begin
         if (empty_len > 0) emit_word(32'd0 - LABEL_W'(empty_len), KIND_EMPTY);
         if (label_len > 0) emit_run_pair();
         empty_len  = '0;
         label_len  = '0;
         open_label = '0;
         row_cnt    = '0;
         col_open   = 1'b0;
         col_cnt    = col_cnt + 1'b1;
         if (col_cnt >= cols_limit()) begin
            col_cnt  = '0;
            word_cnt = '0;
         end
      end

      if (item_word_cnt > 0) item_words[item_word_cnt-1].last = 1'b1;
      for (int i = 0; i < item_word_cnt; i++) pending_words.push_back(item_words[i]);
   endfunction

   // ---------------------------------------------------------------------------
   // Monitors, checker and watchdog
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("testbench: %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) encode_label(req_ch.track_label);
   end

   always @(posedge clock) begin
      coded_word_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with nothing expected", rsp_ch.code_word, 32'd0);
         end else begin
            w = pending_words.pop_front();
            if (rsp_ch.code_word !== w.code)
               report_mismatch("code_word", rsp_ch.code_word, w.code);
            if (rsp_ch.word_kind !== w.kind)
               report_mismatch("word_kind", 32'(rsp_ch.word_kind), 32'(w.kind));
            if (rsp_ch.word_position !== w.pos)
               report_mismatch("word_position", 32'(rsp_ch.word_position), 32'(w.pos));
            if (rsp_ch.column_first !== w.first)
               report_mismatch("column_first", 32'(rsp_ch.column_first), 32'(w.first));
            if (rsp_ch.last_of_item !== w.last)
               report_mismatch("last_of_item", 32'(rsp_ch.last_of_item), 32'(w.last));
         end
      end
   end

   // Register writes count as activity too, so the watchdog only fires on a hang.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stall bursts, or one long hold-off when a test asks.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end else if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers; all are entered and left just after a rising edge.
   // ---------------------------------------------------------------------------

   // Offers one label and returns on the edge that accepts it. valid stays
   // high afterwards so back-to-back items need no extra assignment.
   task automatic send_label(input logic signed [LABEL_W-1:0] lab);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.track_label <= lab;
      do @(posedge clock); while (!req_ch.ready);
      labels_sent++;
   endtask

   // Stops offering and waits until every expected word is in, plus a margin
   // for items that make no word but still move the back end.
   task automatic drain_words();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is always high.
   task automatic set_register(input logic idx, input logic [CSR_DATA_W-1:0] value);
      drain_words();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == CSR_ROWS) rows_reg = value[ROWS_W-1:0];
      else                 cols_reg = value[COLS_W-1:0];
   endtask

   // Upper bits of the bus word are junk the register must ignore.
   function automatic logic [CSR_DATA_W-1:0] junk_upper(input int unsigned field, input int w);
      logic [CSR_DATA_W-1:0] v;
      v = $urandom;
      for (int i = 0; i < w; i++) v[i] = field[i];
      return v;
   endfunction

   function automatic logic signed [LABEL_W-1:0] empty_label();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 32'h8000_0000;
         2:       return -1;
         default: return {1'b1, 31'($urandom)};
      endcase
   endfunction

   function automatic logic signed [LABEL_W-1:0] positive_label();
      logic [LABEL_W-1:0] v;
      v = {1'b0, 31'($urandom)};
      return (v == 0) ? 32'sd1 : v;
   endfunction

   task automatic send_run(input bit is_empty, input logic signed [LABEL_W-1:0] lab,
                           input int len);
      for (int i = 0; i < len; i++) send_label(is_empty ? empty_label() : lab);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset values of the registers; a column that opens with a label, a
   // label change with no empty gap, and the extremes of the label.
   task automatic test_column_opening();
      send_label(9);
      send_label(9);
      send_label(4);
      send_label(0);
      send_label(-7);
      send_label(32'h8000_0000);
      send_label(32'h7FFF_FFFF);
      send_label(32'h7FFF_FFFF);
      send_label(32'hFFFF_FFFF);
      send_label(1);
   endtask

   // Limits lowered mid-column, zero and oversized register values.
   task automatic test_register_limits();
      set_register(CSR_ROWS, junk_upper(3, ROWS_W));   // row count already past 3
      set_register(CSR_COLS, junk_upper(2, COLS_W));
      send_label(5);
      send_label(0);
      send_label(0);
      send_label(6);
      send_label(6);
      send_label(-2);
      set_register(CSR_ROWS, 32'd0);                  // acts as one row
      send_label(3);
      send_label(-1);
      set_register(CSR_COLS, 32'd0);                  // acts as one column
      send_label(8);
      set_register(CSR_ROWS, junk_upper(2047, ROWS_W)); // clamps to the maximum
      set_register(CSR_COLS, junk_upper(8191, COLS_W));
      send_label(2);
      send_label(2);
      send_label(0);
   endtask

   // Close the open column, then a couple of taller columns of mixed runs.
   task automatic test_full_column();
      set_register(CSR_ROWS, 32'd1);
      while (row_cnt != 0 || empty_len != 0 || label_len != 0) send_label(0);
      set_register(CSR_ROWS, 32'd48);
      for (int n = 0; n < 100; ) begin
         int len;
         len = $urandom_range(1, 20);
         send_run($urandom_range(0, 1) == 1, positive_label(), len);
         n += len;
      end
   endtask

   // One-row columns over several short buffers: position restarts at the end.
   // A label in a one-row column gives the most words an item can cause.
   task automatic test_buffer_restart();
      set_register(CSR_ROWS, 32'd1);
      set_register(CSR_COLS, junk_upper(6, COLS_W));
      for (int i = 0; i < 20; i++)
         send_label((i % 3 == 2) ? empty_label() : positive_label());
   endtask

   // Mostly well-formed runs from a small pool of labels, some noise, and a
   // new register setting every few dozen items; idling on both sides.
   task automatic test_random_runs();
      logic signed [LABEL_W-1:0] pool[4];
      int start;
      int phase_end;
      int r;
      idling_on = 1'b1;
      start = labels_sent;
      while (labels_sent - start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         set_register(CSR_ROWS, junk_upper((r < 3) ? r : (r == 9) ? 40 :
                                           $urandom_range(3, 16), ROWS_W));
         r = $urandom_range(0, 7);
         set_register(CSR_COLS, junk_upper((r < 2) ? r : (r == 2) ? 8191 :
                                           $urandom_range(2, 6), COLS_W));
         foreach (pool[i]) pool[i] = positive_label();
         pool[0] = 1;
         if ($urandom_range(0, 1)) pool[1] = 32'h7FFF_FFFF;
         phase_end = labels_sent + $urandom_range(30, 70);
         while (labels_sent < phase_end) begin
            if ($urandom_range(0, 4) == 0)
               send_label($urandom_range(0, 1) ? empty_label() : $signed($urandom));
            else
               send_run($urandom_range(0, 2) == 0, pool[$urandom_range(0, 3)],
                        $urandom_range(1, 8));
         end
      end
      idling_on = 1'b0;
   endtask

   // The receiver holds off while the sender keeps offering label changes,
   // so the command queue fills and the input stalls.
   task automatic test_backpressure();
      set_register(CSR_ROWS, 32'd16);
      set_register(CSR_COLS, 32'd5);
      long_hold = 300;
      for (int i = 0; i < 40; i++) send_label((i % 2) ? 32'sd11 : 32'sd12);
   endtask

   // Last stretch: no idling at all.
   task automatic test_flat_out();
      set_register(CSR_ROWS, 32'd7);
      for (int i = 0; i < 40; i++)
         send_label($urandom_range(0, 2) == 0 ? empty_label()
                                              : 32'($urandom_range(1, 3)));
   endtask

   initial begin
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.track_label <= '0;
      reset_encoder_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_column_opening();
      test_register_limits();
      test_full_column();
      test_buffer_restart();
      test_random_runs();
      test_backpressure();
      test_flat_out();

      drain_words();
      if (pending_words.size() != 0)
         report_mismatch("words never seen", pending_words.size(), 32'd0);
      if (mismatches == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
